// ===== src/lfid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types, codes and defaults for the lowest-free ID allocator.
// ----------------------------------------------------------------------------
package lfid_pkg;

    // Width of IDs, the base register and issued results
    localparam int ID_W = 64;

    // Default geometry of the ID store
    localparam int DEF_LEVELS    = 16;
    localparam int DEF_LEVEL_LEN = 64;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_MARK_USED = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_APPLY
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic div_en;
        logic read_en;
        logic apply_en;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ===== src/lfid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_ctrl
// Sequencer for one request: capture, level split, word read, apply.
// ----------------------------------------------------------------------------
module lfid_ctrl
    import lfid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the request steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_en = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read_en = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY: begin
                // wait while the previous result is still unclaimed
                if (!dp_status.out_busy) begin
                    cmd.apply_en = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lfid_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_datapath
// Bitmap store, level flags, used count and result register of the allocator.
// ----------------------------------------------------------------------------
module lfid_datapath
    import lfid_pkg::*;
#(
    parameter int LEVELS    = DEF_LEVELS,
    parameter int LEVEL_LEN = DEF_LEVEL_LEN
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [ID_W-1:0] cfg_data,
    input  logic [ID_W-1:0] s_tdata,
    input  logic [1:0]      s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [ID_W-1:0] m_tdata,
    output logic [2:0]      m_tuser,
    input  cmd_t            cmd,
    output dp_status_t      dp_status
);

    localparam int TOTAL = LEVELS * LEVEL_LEN;
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int BIT_W = (LEVEL_LEN > 1) ? $clog2(LEVEL_LEN) : 1;
    localparam int OFF_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W = $clog2(TOTAL + 1);
    localparam int PW    = LVL_W + BIT_W + 1;
    localparam int RSH   = 32;
    localparam int MUL_W = OFF_W + RSH + 1;

    // Reciprocal of the level length; exact for offsets below 2^16
    localparam logic [RSH:0]       RECIP = (RSH + 1)'((64'd1 << RSH) / LEVEL_LEN + 64'd1);
    localparam logic [BIT_W:0]     LEN_C = (BIT_W + 1)'(LEVEL_LEN);
    localparam logic [ID_W-1:0]    TOTAL_C = ID_W'(TOTAL);
    localparam logic [LEVEL_LEN-1:0] ONES = '1;

    // Bitmap memory, one word per level
    logic [LEVEL_LEN-1:0] mem [LEVELS];

    logic [ID_W-1:0]      base_reg;
    op_t                  op_reg;
    logic [OFF_W-1:0]     off_reg;
    logic                 range_ok_reg;
    logic [LVL_W-1:0]     q_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [OFF_W-1:0]     lvl_base_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [LEVEL_LEN-1:0] rdata_reg;
    logic                 word_valid_reg;
    logic                 any_free_reg;
    logic [LEVELS-1:0]    valid_flags_reg;
    logic [LEVELS-1:0]    full_flags_reg;
    logic [CNT_W-1:0]     used_cnt_reg;
    logic                 m_valid_reg;
    logic [ID_W-1:0]      res_id_reg;
    status_t              res_status_reg;
    logic                 res_all_free_reg;

    // Offset of the requested ID from the first issued ID
    logic [ID_W-1:0] off64;
    assign off64 = s_tdata - base_reg - ID_W'(1);

    // Level of the offset by reciprocal multiply
    logic [MUL_W-1:0] prod;
    assign prod = MUL_W'(off_reg) * MUL_W'(RECIP);

    // Lowest level that is not full
    logic [LEVELS-1:0] nf_oh;
    logic [LVL_W-1:0]  free_lvl;
    logic              any_free;
    assign nf_oh    = ~full_flags_reg & (full_flags_reg + LEVELS'(1));
    assign any_free = ~(&full_flags_reg);

    always_comb begin
        free_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (nf_oh[i]) begin
                free_lvl = free_lvl | LVL_W'(i);
            end
        end
    end

    // Level chosen for the word read
    logic [LVL_W-1:0] lvl_sel;
    logic [PW-1:0]    sel_base;
    logic [PW-1:0]    q_base;
    assign lvl_sel  = (op_reg == OP_ALLOC) ? free_lvl : q_reg;
    assign sel_base = PW'(lvl_sel) * PW'(LEN_C);
    assign q_base   = PW'(q_reg) * PW'(LEN_C);

    // Current word and lowest zero bit
    logic [LEVEL_LEN-1:0] word;
    logic [LEVEL_LEN-1:0] zero_oh;
    logic [BIT_W-1:0]     zero_bit;
    logic [LEVEL_LEN-1:0] bit_oh;
    assign word    = word_valid_reg ? rdata_reg : '0;
    assign zero_oh = ~word & (word + LEVEL_LEN'(1));
    assign bit_oh  = LEVEL_LEN'(1) << bit_reg;

    always_comb begin
        zero_bit = '0;
        for (int i = 0; i < LEVEL_LEN; i++) begin
            if (zero_oh[i]) begin
                zero_bit = zero_bit | BIT_W'(i);
            end
        end
    end

    // Effect of the request on word, flags and count
    logic [LEVEL_LEN-1:0] new_word;
    logic                 do_write;
    logic                 cnt_inc;
    logic                 cnt_dec;
    logic                 clear_all;
    logic [ID_W-1:0]      res_id;
    status_t              res_status;
    logic [CNT_W-1:0]     used_next;

    always_comb begin
        new_word   = word;
        do_write   = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        clear_all  = 1'b0;
        res_id     = '0;
        res_status = STAT_OK;
        unique case (op_reg)
            OP_ALLOC: begin
                if (any_free_reg) begin
                    new_word = word | zero_oh;
                    do_write = 1'b1;
                    cnt_inc  = 1'b1;
                    res_id   = base_reg + ID_W'(lvl_base_reg) + ID_W'(zero_bit) + ID_W'(1);
                end else begin
                    res_status = STAT_FULL;
                end
            end
            OP_MARK_USED: begin
                if (range_ok_reg) begin
                    new_word = word | bit_oh;
                    do_write = 1'b1;
                    cnt_inc  = ((word & bit_oh) == '0);
                end else begin
                    res_status = STAT_RANGE;
                end
            end
            OP_MARK_FREE: begin
                if (range_ok_reg) begin
                    new_word = word & ~bit_oh;
                    do_write = 1'b1;
                    cnt_dec  = ((word & bit_oh) != '0);
                end else begin
                    res_status = STAT_RANGE;
                end
            end
            OP_CLEAR: begin
                clear_all = 1'b1;
            end
            default: begin
                clear_all = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (clear_all) begin
            used_next = '0;
        end else if (cnt_inc) begin
            used_next = used_cnt_reg + CNT_W'(1);
        end else if (cnt_dec) begin
            used_next = used_cnt_reg - CNT_W'(1);
        end else begin
            used_next = used_cnt_reg;
        end
    end

    // Payload pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= op_t'(s_tuser);
            off_reg      <= off64[OFF_W-1:0];
            range_ok_reg <= (off64 < TOTAL_C);
        end
        if (cmd.div_en) begin
            q_reg <= prod[RSH +: LVL_W];
        end
        if (cmd.read_en) begin
            lvl_reg        <= lvl_sel;
            lvl_base_reg   <= sel_base[OFF_W-1:0];
            bit_reg        <= BIT_W'(off_reg - q_base[OFF_W-1:0]);
            rdata_reg      <= mem[lvl_sel];
            word_valid_reg <= valid_flags_reg[lvl_sel];
            any_free_reg   <= any_free;
        end
        if (cmd.apply_en) begin
            res_id_reg       <= res_id;
            res_status_reg   <= res_status;
            res_all_free_reg <= (used_next == '0);
        end
    end

    // Write back the level word
    always_ff @(posedge aclk) begin
        if (cmd.apply_en && do_write) begin
            mem[lvl_reg] <= new_word;
        end
    end

    // Level flags, used count, base and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_flags_reg <= '0;
            full_flags_reg  <= '0;
            used_cnt_reg    <= '0;
            base_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && (used_cnt_reg == '0)) begin
                base_reg <= cfg_data;
            end
            if (cmd.apply_en) begin
                used_cnt_reg <= used_next;
                if (clear_all) begin
                    valid_flags_reg <= '0;
                    full_flags_reg  <= '0;
                end else if (do_write) begin
                    valid_flags_reg[lvl_reg] <= 1'b1;
                    full_flags_reg[lvl_reg]  <= (new_word == ONES);
                end
            end
            if (cmd.apply_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.out_busy = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_id_reg;
    assign m_tuser  = {res_all_free_reg, res_status_reg};

endmodule

// ===== src/lowest_free_id_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_core
// Lowest-free ID allocator over a leveled bitmap with mark and clear requests.
// ----------------------------------------------------------------------------
// Each request runs through the steps of the sequencer: accept and offset
// subtract, level split by a reciprocal multiply, read of the level word
// from the bitmap memory, then find-first-zero and write back. The result
// register is loaded in the write-back step. Requests are not taken while
// the sequencer is busy with the previous one, and each request makes a
// single read-then-write of the memory. A new request is accepted as soon
// as the sequencer is idle, even while the previous result still waits on
// the master side; a result waiting there delays the write-back step of
// the next request only. Issued IDs are
// base_id + level * LEVEL_LEN + bit + 1; clear-all empties the store in one
// step with no memory sweep. Write base_id only while all IDs are free
// (m_tuser all_free high); other writes are dropped.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core
    import lfid_pkg::*;
#(
    parameter int LEVELS    = DEF_LEVELS,
    parameter int LEVEL_LEN = DEF_LEVEL_LEN
) (
    input  logic            aclk,
    input  logic            aresetn,
    // base_id write channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] cfg_data,     // base_id
    // request channel
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [ID_W-1:0] s_tdata,      // [63:0] id
    input  logic [1:0]      s_tuser,      // [1:0] operation
    // result channel
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [ID_W-1:0] m_tdata,      // [63:0] result_id
    output logic [2:0]      m_tuser       // [1:0] status, [2] all_free
);

    cmd_t       cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    lfid_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    lfid_datapath #(
        .LEVELS    (LEVELS),
        .LEVEL_LEN (LEVEL_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

endmodule

// ===== sim/tb_lowest_free_id_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator_core
// Self-checking bench for the lowest-free ID allocator core.
// ----------------------------------------------------------------------------
// A shadow copy of the bitmap, the per-level valid flags, the used counts and
// the base register predicts every result as each request is accepted. The
// checker compares each result field by field with the oldest prediction.
// Named tests cover the basic requests, base register writes, a store filled
// to the last ID, a long output stall, and three random phases with different
// idle patterns on the request and result sides.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator_core;
    import lfid_pkg::*;

    localparam int LEVELS       = DEF_LEVELS;
    localparam int LEVEL_LEN    = DEF_LEVEL_LEN;
    localparam int TOTAL_IDS    = LEVELS * LEVEL_LEN;
    localparam int RANDOM_ITEMS = 432;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 12;
    localparam int PRINT_CAP    = 40;

    // One predicted result
    typedef struct packed {
        logic [ID_W-1:0] result_id;
        status_t         status;
        logic            all_free;
    } alloc_result_t;

    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data;
    logic            s_tvalid;
    logic            s_tready;
    logic [ID_W-1:0] s_tdata;
    logic [1:0]      s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [ID_W-1:0] m_tdata;
    logic [2:0]      m_tuser;

    // Shadow state of the ID store
    logic [ID_W-1:0]      shadow_base;
    logic [LEVEL_LEN-1:0] shadow_map   [LEVELS];
    logic                 shadow_valid [LEVELS];
    logic [6:0]           shadow_count [LEVELS];

    alloc_result_t pending_results[$];
    int            mismatch_count;
    int            results_seen;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            rx_hold_req;

    lowest_free_id_allocator_core #(
        .LEVELS    (LEVELS),
        .LEVEL_LEN (LEVEL_LEN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    function automatic int ids_in_use();
        int i;
        int total;
        total = 0;
        for (i = 0; i < LEVELS; i++) total += shadow_count[i];
        return total;
    endfunction

    function automatic void clear_store();
        int i;
        for (i = 0; i < LEVELS; i++) begin
            shadow_map[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_count[i] = '0;
        end
    endfunction

    // First touch of a level zeroes its word
    function automatic void open_level(input int lvl);
        if (!shadow_valid[lvl]) begin
            shadow_valid[lvl] = 1'b1;
            shadow_map[lvl]   = '0;
        end
    endfunction

    // Apply one accepted request to the shadow store and return its result
    function automatic alloc_result_t predict_request(input op_t op, input logic [ID_W-1:0] id);
        alloc_result_t r;
        logic [ID_W-1:0] off;
        int i;
        int lvl;
        int b;
        r.result_id = '0;
        r.status    = STAT_OK;
        case (op)
            OP_ALLOC: begin
                lvl = -1;
                b   = -1;
                for (i = 0; i < LEVELS; i++) begin
                    if (lvl < 0 && (!shadow_valid[i] || shadow_count[i] < LEVEL_LEN)) lvl = i;
                end
                if (lvl >= 0) begin
                    open_level(lvl);
                    for (i = 0; i < LEVEL_LEN; i++) begin
                        if (b < 0 && !shadow_map[lvl][i]) b = i;
                    end
                end
                if (b >= 0) begin
                    shadow_map[lvl][b] = 1'b1;
                    shadow_count[lvl] += 7'd1;
                    r.result_id = shadow_base + 64'(lvl * LEVEL_LEN + b) + 64'd1;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            OP_MARK_USED, OP_MARK_FREE: begin
                off = id - shadow_base - 64'd1;
                if (off >= 64'(TOTAL_IDS)) begin
                    r.status = STAT_RANGE;
                end else begin
                    lvl = int'(off / 64'(LEVEL_LEN));
                    b   = int'(off % 64'(LEVEL_LEN));
                    open_level(lvl);
                    if (op == OP_MARK_USED && !shadow_map[lvl][b]) begin
                        shadow_map[lvl][b] = 1'b1;
                        shadow_count[lvl] += 7'd1;
                    end else if (op == OP_MARK_FREE && shadow_map[lvl][b]) begin
                        shadow_map[lvl][b] = 1'b0;
                        shadow_count[lvl] -= 7'd1;
                    end
                end
            end
            default: clear_store();
        endcase
        r.all_free = (ids_in_use() == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic op_t pick_op();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 42) return OP_ALLOC;
        if (k < 65) return OP_MARK_USED;
        if (k < 99) return OP_MARK_FREE;
        return OP_CLEAR;
    endfunction

    // IDs near the low end where allocations land, anywhere in range, plus edges and noise
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 45) return shadow_base + 64'd1 + 64'($urandom_range(255));
        if (k < 75) return shadow_base + 64'd1 + 64'($urandom_range(TOTAL_IDS - 1));
        if (k < 88) begin
            case ($urandom_range(3))
                0: return shadow_base;
                1: return shadow_base + 64'(TOTAL_IDS);
                2: return shadow_base + 64'(TOTAL_IDS) + 64'd1;
                default: return shadow_base + 64'd1;
            endcase
        end
        return {$urandom(), $urandom()};
    endfunction

    // Offer one request, hold it until accepted, then record its prediction
    task automatic send_request(input op_t op, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_request(op, id));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Write base_id; the block keeps it only when no ID is in use
    task automatic write_base(input logic [ID_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (ids_in_use() == 0) shadow_base = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(input string field, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] result %0d %s: got 0x%016h want 0x%016h",
                     $time, results_seen, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, long hold, checker, watchdog
    // ------------------------------------------------------------------

    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        alloc_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.result_id)
                        flag_mismatch("result_id", m_tdata, want.result_id);
                    if (m_tuser[1:0] !== want.status)
                        flag_mismatch("status", 64'(m_tuser[1:0]), 64'(want.status));
                    if (m_tuser[2] !== want.all_free)
                        flag_mismatch("all_free", 64'(m_tuser[2]), 64'(want.all_free));
                end
                results_seen++;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("lowest_free_id_allocator_core verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Allocate, marks on used and free IDs, range edges, clear
    task automatic test_basic_requests();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_MARK_USED, 64'd1);
        send_request(OP_MARK_FREE, 64'd3);
        send_request(OP_MARK_FREE, 64'd2);
        send_request(OP_ALLOC, '1);
        send_request(OP_MARK_USED, 64'd0);
        send_request(OP_MARK_USED, 64'(TOTAL_IDS) + 64'd1);
        send_request(OP_MARK_FREE, '1);
        send_request(OP_MARK_USED, 64'(TOTAL_IDS));
        send_request(OP_MARK_USED, 64'd64);
        send_request(OP_MARK_USED, 64'd65);
        send_request(OP_MARK_FREE, 64'(TOTAL_IDS));
        send_request(OP_ALLOC, 64'h5555_5555_5555_5555);
        send_request(OP_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_MARK_FREE, 64'd5);
        drain_results();
    endtask

    // Write dropped while in use, then the extremes of base_id
    task automatic test_base_register();
        send_request(OP_ALLOC, '0);
        drain_results();
        write_base(64'h0000_0000_0000_1234);
        send_request(OP_ALLOC, '0);
        send_request(OP_CLEAR, '0);
        drain_results();
        write_base('1);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_MARK_USED, '1);
        send_request(OP_MARK_USED, 64'd1022);
        send_request(OP_MARK_FREE, 64'd0);
        send_request(OP_CLEAR, '0);
        drain_results();
        write_base('0);
        send_request(OP_ALLOC, '0);
        send_request(OP_CLEAR, '0);
        drain_results();
    endtask

    // Fill every ID with issued IDs wrapping past zero, then hit full
    task automatic test_store_full();
        logic [ID_W-1:0] id;
        write_base(64'hFFFF_FFFF_FFFF_FE00);
        while (ids_in_use() < TOTAL_IDS) begin
            if ($urandom_range(3) != 0)
                send_request(OP_ALLOC, {$urandom(), $urandom()});
            else
                send_request(OP_MARK_USED, shadow_base + 64'd1 + 64'($urandom_range(TOTAL_IDS - 1)));
        end
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        send_request(OP_MARK_USED, shadow_base + 64'd700);
        id = shadow_base + 64'd1 + 64'($urandom_range(TOTAL_IDS - 1));
        send_request(OP_MARK_FREE, id);
        send_request(OP_ALLOC, '0);
        send_request(OP_MARK_FREE, shadow_base + 64'(TOTAL_IDS));
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_CLEAR, '0);
        drain_results();
        write_base('0);
        send_request(OP_ALLOC, '0);
        drain_results();
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_output_stall();
        int n;
        rx_hold_req = 300;
        for (n = 0; n < 30; n++) send_request(pick_op(), pick_id());
        drain_results();
    endtask

    // Random phases: each starts with a base write, dropped while IDs are in use, a clear and a new base
    task automatic test_random_traffic();
        int phase;
        int n;
        logic [ID_W-1:0] phase_base [3];
        phase_base[0] = {$urandom(), $urandom()};
        phase_base[1] = 64'hFFFF_FFFF_FFFF_FF00;
        phase_base[2] = '0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 29; rx_idle_pct = 78; end
                1: begin tx_idle_pct = 78; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            write_base({$urandom(), $urandom()});
            send_request(OP_CLEAR, '0);
            drain_results();
            write_base(phase_base[phase]);
            for (n = 0; n < RANDOM_ITEMS / 3; n++) send_request(pick_op(), pick_id());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_ALLOC;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_req    = 0;
        mismatch_count = 0;
        results_seen   = 0;
        shadow_base    = '0;
        clear_store();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_requests();
        test_base_register();
        test_store_full();
        test_output_stall();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("lowest_free_id_allocator_core verification clean");
        end else begin
            $display("lowest_free_id_allocator_core verification failed");
        end
        $finish;
    end

endmodule
